// ===== hw/rtl/trl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_pkg
// Shared widths, register codes and structs for the tiled raster to linear
// scatter block.
// ----------------------------------------------------------------------------
package trl_pkg;

	// configuration register widths
	localparam int RW_W = 16;
	localparam int RH_W = 16;
	localparam int BW_W = 13;
	localparam int BH_W = 13;
	localparam int EB_W = 5;

	localparam int BLOCK_MAX = 4096;
	localparam int EB_MAX    = 16;

	// payload widths
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 36;

	// internal widths
	localparam int ROWADDR_W = 37;
	localparam int LINE_W    = 20;
	localparam int ROWB_W    = 17;
	localparam int GBYTE_W   = 21;
	localparam int GROW_W    = 17;
	localparam int BCNT_W    = 16;
	localparam int RCNT_W    = 12;
	localparam int PROD_W    = 32;

	// apb port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_RASTER_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RASTER_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd4;

	// geometry derived from the registers, all values effective
	typedef struct packed {
		logic [LINE_W-1:0]  line_bytes;
		logic [ROWB_W-1:0]  row_bytes;
		logic [BH_W-1:0]    bh;
		logic [RH_W-1:0]    h;
		logic [ADDR_W-1:0]  last_addr;
	} trl_geom_t;

	// position of the byte being taken in
	typedef struct packed {
		logic [ROWADDR_W-1:0] row_addr;
		logic [GBYTE_W-1:0]   gbyte;
		logic [GROW_W-1:0]    grow;
	} trl_pos_t;

endpackage

// ===== hw/rtl/trl_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_stream_if
// Valid/ready channels for tile bytes in and placed bytes out.
// ----------------------------------------------------------------------------
interface trl_in_if import trl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tile_byte;

	modport source (output valid, output tile_byte, input ready);
	modport sink   (input valid, input tile_byte, output ready);
endinterface

interface trl_out_if import trl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] dest_address;
	logic [BYTE_W-1:0] dest_byte;
	logic              raster_done;

	modport source (output valid, output dest_address, output dest_byte,
		output raster_done, input ready);
	modport sink   (input valid, input dest_address, input dest_byte,
		input raster_done, output ready);
endinterface

// ===== hw/rtl/trl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_cfg_regs
// APB register file and the two-stage pipeline that derives the geometry.
// ----------------------------------------------------------------------------
module trl_cfg_regs import trl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  clear,
	output logic                  busy,
	output trl_geom_t             geom
);

	localparam int SETTLE_CYCLES = 2;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	logic [RW_W-1:0] raster_width_q;
	logic [RH_W-1:0] raster_height_q;
	logic [BW_W-1:0] block_width_q;
	logic [BH_W-1:0] block_height_q;
	logic [EB_W-1:0] element_bytes_q;

	logic [RW_W-1:0]   w_e_q;
	logic [RH_W-1:0]   h_e_q;
	logic [BW_W-1:0]   bw_e_q;
	logic [BH_W-1:0]   bh_e_q;
	logic [EB_W-1:0]   eb_e_q;
	logic [PROD_W-1:0] wh_q;
	trl_geom_t         geom_q;
	logic [SETTLE_W-1:0] settle_q;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr;
	logic                 idx_ok;
	logic [RW_W-1:0]      w_e;
	logic [RH_W-1:0]      h_e;
	logic [BW_W-1:0]      bw_e;
	logic [BH_W-1:0]      bh_e;
	logic [EB_W-1:0]      eb_e;
	trl_geom_t            geom_d;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign idx_ok = (idx == REG_RASTER_WIDTH) || (idx == REG_RASTER_HEIGHT) ||
		(idx == REG_BLOCK_WIDTH) || (idx == REG_BLOCK_HEIGHT) ||
		(idx == REG_ELEMENT_BYTES);
	assign clear  = wr && idx_ok;
	assign pready = 1'b1;
	assign busy   = (settle_q != '0);
	assign geom   = geom_q;

	// zero acts as one, oversize clamps
	assign w_e  = (raster_width_q == '0) ? RW_W'(1) : raster_width_q;
	assign h_e  = (raster_height_q == '0) ? RH_W'(1) : raster_height_q;
	assign bw_e = (block_width_q == '0) ? BW_W'(1) :
		(block_width_q > BW_W'(BLOCK_MAX)) ? BW_W'(BLOCK_MAX) : block_width_q;
	assign bh_e = (block_height_q == '0) ? BH_W'(1) :
		(block_height_q > BH_W'(BLOCK_MAX)) ? BH_W'(BLOCK_MAX) : block_height_q;
	assign eb_e = (element_bytes_q == '0) ? EB_W'(1) :
		(element_bytes_q > EB_W'(EB_MAX)) ? EB_W'(EB_MAX) : element_bytes_q;

	always_comb begin
		geom_d.line_bytes = LINE_W'(w_e_q) * LINE_W'(eb_e_q);
		geom_d.row_bytes  = ROWB_W'(bw_e_q) * ROWB_W'(eb_e_q);
		geom_d.bh         = bh_e_q;
		geom_d.h          = h_e_q;
		geom_d.last_addr  = ADDR_W'(wh_q) * ADDR_W'(eb_e_q) - ADDR_W'(1);
	end

	always_comb begin
		unique case (idx)
			REG_RASTER_WIDTH:  prdata = APB_DATA_W'(raster_width_q);
			REG_RASTER_HEIGHT: prdata = APB_DATA_W'(raster_height_q);
			REG_BLOCK_WIDTH:   prdata = APB_DATA_W'(block_width_q);
			REG_BLOCK_HEIGHT:  prdata = APB_DATA_W'(block_height_q);
			REG_ELEMENT_BYTES: prdata = APB_DATA_W'(element_bytes_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_width_q  <= RW_W'(1);
			raster_height_q <= RH_W'(1);
			block_width_q   <= BW_W'(1);
			block_height_q  <= BH_W'(1);
			element_bytes_q <= EB_W'(1);
		end else if (wr) begin
			unique case (idx)
				REG_RASTER_WIDTH:  raster_width_q  <= pwdata[RW_W-1:0];
				REG_RASTER_HEIGHT: raster_height_q <= pwdata[RH_W-1:0];
				REG_BLOCK_WIDTH:   block_width_q   <= pwdata[BW_W-1:0];
				REG_BLOCK_HEIGHT:  block_height_q  <= pwdata[BH_W-1:0];
				REG_ELEMENT_BYTES: element_bytes_q <= pwdata[EB_W-1:0];
				default: ;
			endcase
		end
	end

	// geometry follows the registers through the effective-value registers and geom_q, input is held off meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_e_q     <= RW_W'(1);
			h_e_q     <= RH_W'(1);
			bw_e_q    <= BW_W'(1);
			bh_e_q    <= BH_W'(1);
			eb_e_q    <= EB_W'(1);
			wh_q      <= PROD_W'(1);
			geom_q.line_bytes <= LINE_W'(1);
			geom_q.row_bytes  <= ROWB_W'(1);
			geom_q.bh         <= BH_W'(1);
			geom_q.h          <= RH_W'(1);
			geom_q.last_addr  <= '0;
			settle_q  <= '0;
		end else begin
			w_e_q  <= w_e;
			h_e_q  <= h_e;
			bw_e_q <= bw_e;
			bh_e_q <= bh_e;
			eb_e_q <= eb_e;
			wh_q   <= PROD_W'(w_e) * PROD_W'(h_e);
			geom_q <= geom_d;
			if (wr)
				settle_q <= SETTLE_W'(SETTLE_CYCLES);
			else if (settle_q != '0)
				settle_q <= settle_q - SETTLE_W'(1);
		end
	end

endmodule

// ===== hw/rtl/trl_pos_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_pos_counter
// Incremental tile position counters and raster row base address.
// ----------------------------------------------------------------------------
module trl_pos_counter import trl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      clear,
	input  logic      step,
	input  trl_geom_t geom,
	output trl_pos_t  pos
);

	logic [BCNT_W-1:0]    b_q;
	logic [RCNT_W-1:0]    r_q;
	logic [LINE_W-1:0]    col_base_q;
	logic [GROW_W-1:0]    grow_q;
	logic [GROW_W-1:0]    trow_grow_q;
	logic [ROWADDR_W-1:0] row_addr_q;
	logic [ROWADDR_W-1:0] trow_addr_q;

	logic                 byte_end;
	logic                 row_end;
	logic                 col_end;
	logic                 trow_end;
	logic [GBYTE_W-1:0]   col_next;
	logic [GROW_W:0]      trow_next;
	logic [GROW_W-1:0]    grow_inc;
	logic [ROWADDR_W-1:0] row_addr_inc;

	assign byte_end  = (ROWB_W'(b_q) + ROWB_W'(1)) >= geom.row_bytes;
	assign row_end   = (BH_W'(r_q) + BH_W'(1)) >= geom.bh;
	assign col_next  = GBYTE_W'(col_base_q) + GBYTE_W'(geom.row_bytes);
	assign col_end   = col_next >= GBYTE_W'(geom.line_bytes);
	assign trow_next = (GROW_W+1)'(trow_grow_q) + (GROW_W+1)'(geom.bh);
	assign trow_end  = trow_next >= (GROW_W+1)'(geom.h);
	assign grow_inc     = grow_q + GROW_W'(1);
	assign row_addr_inc = row_addr_q + ROWADDR_W'(geom.line_bytes);

	assign pos.row_addr = row_addr_q;
	assign pos.gbyte    = GBYTE_W'(col_base_q) + GBYTE_W'(b_q);
	assign pos.grow     = grow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q         <= '0;
			r_q         <= '0;
			col_base_q  <= '0;
			grow_q      <= '0;
			trow_grow_q <= '0;
			row_addr_q  <= '0;
			trow_addr_q <= '0;
		end else if (clear) begin
			b_q         <= '0;
			r_q         <= '0;
			col_base_q  <= '0;
			grow_q      <= '0;
			trow_grow_q <= '0;
			row_addr_q  <= '0;
			trow_addr_q <= '0;
		end else if (step) begin
			if (!byte_end) begin
				b_q <= b_q + BCNT_W'(1);
			end else begin
				b_q <= '0;
				if (!row_end) begin
					r_q        <= r_q + RCNT_W'(1);
					grow_q     <= grow_inc;
					row_addr_q <= row_addr_inc;
				end else begin
					r_q <= '0;
					if (!col_end) begin
						// next tile in the same tile row starts at its top row
						col_base_q <= col_next[LINE_W-1:0];
						grow_q     <= trow_grow_q;
						row_addr_q <= trow_addr_q;
					end else begin
						col_base_q <= '0;
						if (!trow_end) begin
							grow_q      <= grow_inc;
							row_addr_q  <= row_addr_inc;
							trow_grow_q <= grow_inc;
							trow_addr_q <= row_addr_inc;
						end else begin
							grow_q      <= '0;
							row_addr_q  <= '0;
							trow_grow_q <= '0;
							trow_addr_q <= '0;
						end
					end
				end
			end
		end
	end

	a_grow_tracks_tile_row: assert property (@(posedge clk) disable iff (!arst_n)
		grow_q == trow_grow_q + GROW_W'(r_q))
		else $error("global row out of step with tile row base");

	a_row_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		BH_W'(r_q) < geom.bh)
		else $error("row in tile beyond block height");

	a_byte_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		ROWB_W'(b_q) < geom.row_bytes)
		else $error("byte in tile row beyond tile row length");

	a_col_base: assert property (@(posedge clk) disable iff (!arst_n)
		col_base_q < geom.line_bytes)
		else $error("tile column starts beyond raster right edge");

endmodule

// ===== hw/rtl/trl_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trl_emit
// Input register, edge clipping, address add and result register.
// ----------------------------------------------------------------------------
module trl_emit import trl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         busy,
	input  trl_geom_t    geom,
	input  trl_pos_t     pos,
	output logic         step,
	trl_in_if.sink       tile_in,
	trl_out_if.source    raster_out
);

	logic                 v_s1;
	logic [BYTE_W-1:0]    byte_s1;
	trl_pos_t             pos_s1;

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    dest_address_q;
	logic [BYTE_W-1:0]    dest_byte_q;
	logic                 raster_done_q;

	logic                 hit;
	logic                 out_free;
	logic                 s1_free;
	logic                 in_ready;
	logic [ROWADDR_W-1:0] addr_full;
	logic [ADDR_W-1:0]    addr;

	// padding bytes are dropped here and never wait for the output side
	assign hit = v_s1 && (pos_s1.grow < GROW_W'(geom.h)) &&
		(pos_s1.gbyte < GBYTE_W'(geom.line_bytes));
	assign addr_full = pos_s1.row_addr + ROWADDR_W'(pos_s1.gbyte);
	assign addr      = addr_full[ADDR_W-1:0];

	assign out_free = !out_valid_q || raster_out.ready;
	assign s1_free  = !v_s1 || !hit || out_free;
	assign in_ready = !busy && s1_free;
	assign step     = tile_in.valid && in_ready;

	assign tile_in.ready           = in_ready;
	assign raster_out.valid        = out_valid_q;
	assign raster_out.dest_address = dest_address_q;
	assign raster_out.dest_byte    = dest_byte_q;
	assign raster_out.raster_done  = raster_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				v_s1 <= step;
			if (out_free)
				out_valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_s1 <= tile_in.tile_byte;
			pos_s1  <= pos;
		end
		if (out_free && hit) begin
			dest_address_q <= addr;
			dest_byte_q    <= byte_s1;
			raster_done_q  <= (addr == geom.last_addr);
		end
	end

endmodule

// ===== hw/rtl/tiled_raster_to_linear_scatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_raster_to_linear_scatter_top
// Detiling address generator: tiled raster bytes in, row-major byte addresses out.
// ----------------------------------------------------------------------------
// Feed the bytes of padded tiles, one per transfer, tile rows top to bottom,
// tiles left to right, each tile row-major. Every byte inside the raster comes
// out with its byte offset in the row-major raster; padding bytes past the
// right or bottom edge are consumed and give no output, and the last raster
// byte carries raster_done. One byte is taken every clock unless a byte held
// for the stalled output or settling geometry holds input off; a byte reaches
// the output through an input register and a result register, with the
// position tracked by incremental counters and one address add. Any write to
// a defined register restarts the stream at the first tile and holds input
// off while the derived geometry settles.
// Registers (32-bit APB, byte address 4*index): raster_width, raster_height,
// block_width, block_height, element_bytes; zero acts as one, block sizes
// above 4096 act as 4096, element_bytes above 16 acts as 16. Write registers
// only while no transfer is in flight.
module tiled_raster_to_linear_scatter_top import trl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	trl_in_if.sink                tile_in,
	trl_out_if.source             raster_out
);

	logic      clear;
	logic      busy;
	logic      step;
	trl_geom_t geom;
	trl_pos_t  pos;

	trl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clear   (clear),
		.busy    (busy),
		.geom    (geom)
	);

	trl_pos_counter u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.step   (step),
		.geom   (geom),
		.pos    (pos)
	);

	trl_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.busy       (busy),
		.geom       (geom),
		.pos        (pos),
		.step       (step),
		.tile_in    (tile_in),
		.raster_out (raster_out)
	);

endmodule

// ===== bench/tb_tiled_raster_to_linear_scatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiled_raster_to_linear_scatter_top
// Self-checking bench for the tiled raster to linear scatter block.
// ----------------------------------------------------------------------------
// Streams padded tile bytes through the block under several raster and tile
// geometries, written over APB between streams. A byte-level detiler in the
// bench tracks tile column, tile row, row in tile and byte column. It queues
// the destination address, data and done flag of every byte inside the
// raster, and each output transfer is checked against the oldest entry. The
// sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_tiled_raster_to_linear_scatter_top;
	import trl_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic              done;
	} placed_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	trl_in_if  tile_in();
	trl_out_if raster_out();

	tiled_raster_to_linear_scatter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.tile_in    (tile_in),
		.raster_out (raster_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror, raw values at register width
	logic [RW_W-1:0] cfg_width;
	logic [RH_W-1:0] cfg_height;
	logic [BW_W-1:0] cfg_block_w;
	logic [BH_W-1:0] cfg_block_h;
	logic [EB_W-1:0] cfg_elem_bytes;

	// detiler position
	logic [BCNT_W-1:0] tile_col;
	logic [BCNT_W-1:0] tile_row;
	logic [RCNT_W-1:0] tile_line;
	logic [BCNT_W-1:0] line_byte;

	logic [BYTE_W-1:0] byte_q[$];
	placed_t           placed_q[$];
	int unsigned       bytes_queued;
	int unsigned       bytes_taken;
	int unsigned       mismatches;
	logic              in_fire;

	int unsigned burst_left;
	int unsigned gap_left;
	logic [7:0]  rx_tick;
	rx_mode_t    rx_mode;

	function automatic longint unsigned eff_val(longint unsigned v, longint unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic void restart_stream();
		tile_col  = '0;
		tile_row  = '0;
		tile_line = '0;
		line_byte = '0;
	endfunction

	// work out where one tile byte lands, then step the position
	function automatic void place_byte(input logic [BYTE_W-1:0] b);
		longint unsigned w, h, bw, bh, eb, row_bytes, xcnt, ycnt, grow, gbyte, addr;
		placed_t p;
		w         = eff_val(cfg_width, 65535);
		h         = eff_val(cfg_height, 65535);
		bw        = eff_val(cfg_block_w, BLOCK_MAX);
		bh        = eff_val(cfg_block_h, BLOCK_MAX);
		eb        = eff_val(cfg_elem_bytes, EB_MAX);
		row_bytes = bw * eb;
		xcnt      = (w - 1) / bw + 1;
		ycnt      = (h - 1) / bh + 1;
		grow      = tile_row * bh + tile_line;
		gbyte     = tile_col * row_bytes + line_byte;
		if (grow < h && gbyte < w * eb) begin
			addr   = grow * w * eb + gbyte;
			p.addr = addr[ADDR_W-1:0];
			p.data = b;
			p.done = (addr == w * h * eb - 1);
			placed_q = {placed_q, p};
		end
		if (longint'(line_byte) + 1 >= row_bytes) begin
			line_byte = '0;
			if (longint'(tile_line) + 1 >= bh) begin
				tile_line = '0;
				if (longint'(tile_col) + 1 >= xcnt) begin
					tile_col = '0;
					if (longint'(tile_row) + 1 >= ycnt)
						tile_row = '0;
					else
						tile_row = tile_row + 1'b1;
				end else begin
					tile_col = tile_col + 1'b1;
				end
			end else begin
				tile_line = tile_line + 1'b1;
			end
		end else begin
			line_byte = line_byte + 1'b1;
		end
	endfunction

	// monitor: register writes, input transfers and output checks
	always @(posedge clk) begin
		placed_t exp_p;
		placed_t got_p;
		in_fire <= tile_in.valid && tile_in.ready;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_RASTER_WIDTH: begin
						cfg_width = pwdata[RW_W-1:0];
						restart_stream();
					end
					REG_RASTER_HEIGHT: begin
						cfg_height = pwdata[RH_W-1:0];
						restart_stream();
					end
					REG_BLOCK_WIDTH: begin
						cfg_block_w = pwdata[BW_W-1:0];
						restart_stream();
					end
					REG_BLOCK_HEIGHT: begin
						cfg_block_h = pwdata[BH_W-1:0];
						restart_stream();
					end
					REG_ELEMENT_BYTES: begin
						cfg_elem_bytes = pwdata[EB_W-1:0];
						restart_stream();
					end
					default: ;
				endcase
			end
			if (tile_in.valid && tile_in.ready) begin
				place_byte(tile_in.tile_byte);
				bytes_taken++;
			end
			if (raster_out.valid && raster_out.ready) begin
				got_p = '{raster_out.dest_address, raster_out.dest_byte, raster_out.raster_done};
				if (placed_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected output addr %h byte %h done %b",
							$realtime, got_p.addr, got_p.data, got_p.done);
					mismatches++;
				end else begin
					exp_p = placed_q.pop_front();
					if (got_p.addr !== exp_p.addr || got_p.data !== exp_p.data ||
						got_p.done !== exp_p.done) begin
						if (mismatches < 10)
							$display("%0t: mismatch exp %h %h %b, got %h %h %b",
								$realtime, exp_p.addr, exp_p.data, exp_p.done,
								got_p.addr, got_p.data, got_p.done);
						mismatches++;
					end
				end
			end
		end
	end

	// sender: bursts of transfers with gaps between them
	always @(negedge clk) begin
		if (!tile_in.valid || in_fire) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				tile_in.valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				tile_in.valid <= 1'b1;
				tile_in.tile_byte <= byte_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
						: $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				tile_in.valid <= 1'b0;
			end
		end
	end

	// receiver: stall mode is redrawn each time rx_tick[5:0] returns to zero
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (rx_tick[5:0] == 6'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:     raster_out.ready <= 1'b1;
			RX_LIGHT:    raster_out.ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    raster_out.ready <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: raster_out.ready <= (rx_tick[2:0] < 3'd5);
		endcase
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		byte_q = {byte_q, b};
		bytes_queued++;
	endtask

	// wait for every byte taken and placed, then let padding bytes drain
	task automatic drain();
		while (bytes_taken != bytes_queued || placed_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_geometry(input logic [APB_DATA_W-1:0] w, input logic [APB_DATA_W-1:0] h,
		input logic [APB_DATA_W-1:0] bw, input logic [APB_DATA_W-1:0] bh,
		input logic [APB_DATA_W-1:0] eb);
		write_reg(REG_RASTER_WIDTH, w);
		write_reg(REG_RASTER_HEIGHT, h);
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
		write_reg(REG_ELEMENT_BYTES, eb);
	endtask

	initial begin
		int unsigned random_items;
		int unsigned n;
		int unsigned w, h, bw, bh, eb, padded;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		tile_in.valid     = 1'b0;
		tile_in.tile_byte = '0;
		raster_out.ready  = 1'b0;
		in_fire           = 1'b0;
		burst_left        = 1;
		gap_left          = 0;
		rx_tick           = '0;
		rx_mode           = RX_OPEN;
		bytes_queued      = 0;
		bytes_taken       = 0;
		mismatches        = 0;
		random_items      = 0;
		cfg_width         = 1;
		cfg_height        = 1;
		cfg_block_w       = 1;
		cfg_block_h       = 1;
		cfg_elem_bytes    = 1;
		restart_stream();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: every byte is the whole raster
		queue_byte(8'h00);
		queue_byte(8'hFF);
		drain();

		// zero in every register acts as one
		write_geometry(0, 0, 0, 0, 0);
		queue_byte(8'hAA);
		queue_byte(8'h55);
		drain();

		// 3x2 raster in 2x2 tiles: right tile has a padding column, then wrap
		write_geometry(3, 2, 2, 2, 1);
		for (int i = 0; i < 10; i++)
			queue_byte(BYTE_W'(8'h10 + i));
		drain();

		// oversized block sizes and element bytes clamp
		write_geometry(2, 1, 32'hFFFF_FFFF, 32'hFFFF_1388, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			queue_byte(BYTE_W'(8'h80 + i));
		drain();
		// writes to undefined registers leave the stream position alone
		write_reg(REG_SPARE_LO, 32'h0000_0003);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++)
			queue_byte(BYTE_W'(8'hC0 + i));
		drain();

		// largest geometry
		write_geometry(65535, 65535, 4096, 4096, 16);
		for (int i = 0; i < 40; i++)
			queue_byte(BYTE_W'($urandom_range(0, 255)));
		random_items += 40;
		drain();

		while (random_items < 950) begin
			if ($urandom_range(0, 9) < 7) begin
				// small geometry, one whole raster plus up to one more
				w  = $urandom_range(1, 8);
				h  = $urandom_range(1, 6);
				bw = $urandom_range(1, 4);
				bh = $urandom_range(1, 3);
				eb = $urandom_range(1, 3);
				write_geometry(w, h, bw, bh, eb);
				padded = ((w - 1) / bw + 1) * bw * eb * (((h - 1) / bh + 1) * bh);
				n = padded + $urandom_range(0, padded);
			end else begin
				// any register bits, short stream
				write_geometry($urandom, $urandom, $urandom, $urandom, $urandom);
				n = $urandom_range(10, 40);
			end
			if (n > 950 - random_items)
				n = 950 - random_items;
			for (int i = 0; i < n; i++)
				queue_byte(BYTE_W'($urandom_range(0, 255)));
			random_items += n;
			drain();
		end

		drain();
		if (mismatches == 0)
			$display("tiled_raster_to_linear_scatter_top test passed");
		else
			$display("tiled_raster_to_linear_scatter_top test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tiled_raster_to_linear_scatter_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/trl_pkg.sv
hw/rtl/trl_stream_if.sv
hw/rtl/trl_cfg_regs.sv
hw/rtl/trl_pos_counter.sv
hw/rtl/trl_emit.sv
hw/rtl/tiled_raster_to_linear_scatter_top.sv
bench/tb_tiled_raster_to_linear_scatter_top.sv
